// ===== sv/assert_macros.svh =====
// assert_macros.svh: concurrent assertion macros shared by the rtl
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/cfcf_pkg.sv =====
// cfcf_pkg: types, constants and identifier table of the change filter
// no dependencies
`default_nettype none

package cfcf_pkg;

   localparam int DATA_BYTES = 8;
   localparam int NUM_SLOTS  = 11;
   localparam int ID_W       = 12;
   localparam int LEN_W      = 4;
   localparam int DATA_W     = DATA_BYTES * 8;
   localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);

   localparam logic [DATA_W-1:0] SLOT_RESET = {DATA_W{1'b1}};

   localparam logic [ID_W-1:0] ID_TABLE [NUM_SLOTS] = '{
      12'h626, 12'h466, 12'h566, 12'h666, 12'h766, 12'h866,
      12'h200, 12'h201, 12'h188, 12'h388, 12'h488
   };

   typedef struct packed {
      logic [ID_W-1:0]   frame_id;
      logic [LEN_W-1:0]  frame_length;
      logic [DATA_W-1:0] frame_data;
   } req_type;

   typedef struct packed {
      logic              changed;
      logic              known_id;
      logic [DATA_W-1:0] swapped_data;
   } rsp_type;

   typedef struct packed {
      logic changed;
      logic known_id;
   } slot_status_type;

endpackage

`default_nettype wire

// ===== sv/cfcf_swap.sv =====
// cfcf_swap: reverses the first len/2 bytes inside each four-byte half
// depends on cfcf_pkg
`default_nettype none

module cfcf_swap (
   input  wire logic [cfcf_pkg::DATA_W-1:0] data,
   input  wire logic [cfcf_pkg::LEN_W-1:0]  len,
   output logic      [cfcf_pkg::DATA_W-1:0] swapped
);

   localparam int HALF_BYTES = cfcf_pkg::DATA_BYTES / 2;
   localparam int HALF_BITS  = HALF_BYTES * 8;
   localparam int SRC_W      = $clog2(HALF_BYTES);

   logic [cfcf_pkg::LEN_W-2:0] half;

   assign half = len[cfcf_pkg::LEN_W-1:1];

   always_comb begin
      logic [cfcf_pkg::LEN_W-2:0] src_full;
      logic [SRC_W-1:0]           src;
      swapped = data;
      for (int i = 0; i < HALF_BYTES; i++) begin
         src_full = half - (cfcf_pkg::LEN_W-1)'(i) - (cfcf_pkg::LEN_W-1)'(1);
         src      = src_full[SRC_W-1:0];
         if ((cfcf_pkg::LEN_W-1)'(i) < half) begin
            swapped[8*i +: 8]             = data[8*src +: 8];
            swapped[HALF_BITS + 8*i +: 8] = data[HALF_BITS + 8*src +: 8];
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/cfcf_slots.sv =====
// cfcf_slots: identifier match, last-data slots, compare and slot update
// depends on cfcf_pkg
`default_nettype none

module cfcf_slots (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          update,
   input  wire logic [cfcf_pkg::ID_W-1:0]     frame_id,
   input  wire logic [cfcf_pkg::LEN_W-1:0]    len,
   input  wire logic [cfcf_pkg::DATA_W-1:0]   swapped,
   output cfcf_pkg::slot_status_type          status
);

   logic [cfcf_pkg::DATA_W-1:0]     slot_ff [cfcf_pkg::NUM_SLOTS];
   logic [cfcf_pkg::DATA_W-1:0]     slot_in;
   logic [cfcf_pkg::DATA_W-1:0]     slot_rd;
   logic [cfcf_pkg::DATA_W-1:0]     mask;
   logic [cfcf_pkg::SLOT_IDX_W-1:0] idx;
   logic                            hit;
   logic                            diff;
   logic                            wr_en;

   // identifiers are distinct, so the first match is the only one
   always_comb begin
      hit = 1'b0;
      idx = '0;
      for (int i = 0; i < cfcf_pkg::NUM_SLOTS; i++) begin
         if (!hit && frame_id == cfcf_pkg::ID_TABLE[i]) begin
            hit = 1'b1;
            idx = cfcf_pkg::SLOT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < cfcf_pkg::DATA_BYTES; k++) begin
         mask[8*k +: 8] = (cfcf_pkg::LEN_W'(k) < len) ? 8'hFF : 8'h00;
      end
   end

   assign slot_rd = slot_ff[idx];
   assign diff    = |((slot_rd ^ swapped) & mask);
   assign slot_in = (slot_rd & ~mask) | (swapped & mask);
   assign wr_en   = update && hit && diff;

   assign status.known_id = hit;
   assign status.changed  = !hit || diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cfcf_pkg::NUM_SLOTS; i++) begin
            slot_ff[i] <= cfcf_pkg::SLOT_RESET;
         end
      end else if (wr_en) begin
         slot_ff[idx] <= slot_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/can_frame_change_filter.sv =====
// can_frame_change_filter: top level, input register, swap and slot logic, result register
// depends on cfcf_pkg, cfcf_swap, cfcf_slots and assert_macros.svh
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   cfcf_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall   cfcf_pkg::rsp_type
//
// one frame per cycle sustained while the result is not stalled; a taken frame is held in the
// input register until the result register loads, and the result leaves from that register
// the slot read, compare and write sit between the input and result registers,
// so a frame always sees the slot as left by the frame before it
// reset clears both valid registers and sets every slot to all ones
// a stalled result holds the input register; req_stall rises only when both are full
`default_nettype none
`include "assert_macros.svh"

module can_frame_change_filter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire cfcf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cfcf_pkg::rsp_type      rsp_data
);

   logic                          in_valid_ff;
   logic                          in_valid_in;
   cfcf_pkg::req_type             in_data_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   cfcf_pkg::rsp_type             rsp_data_ff;
   cfcf_pkg::rsp_type             rsp_data_in;
   logic                          out_free;
   logic                          advance;
   logic                          take;
   logic [cfcf_pkg::LEN_W-1:0]    len_sat;
   logic [cfcf_pkg::DATA_W-1:0]   swapped;
   cfcf_pkg::slot_status_type     status;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // lengths above eight count as eight
   assign len_sat = (in_data_ff.frame_length > cfcf_pkg::LEN_W'(cfcf_pkg::DATA_BYTES))
                  ? cfcf_pkg::LEN_W'(cfcf_pkg::DATA_BYTES) : in_data_ff.frame_length;

   cfcf_swap u_swap (
      .data    (in_data_ff.frame_data),
      .len     (len_sat),
      .swapped (swapped)
   );

   cfcf_slots u_slots (
      .clock    (clock),
      .reset    (reset),
      .update   (advance),
      .frame_id (in_data_ff.frame_id),
      .len      (len_sat),
      .swapped  (swapped),
      .status   (status)
   );

   always_comb begin
      rsp_data_in.changed      = status.changed;
      rsp_data_in.known_id     = status.known_id;
      rsp_data_in.swapped_data = swapped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, req_stall, in_valid_ff && rsp_valid_ff)
   `ASSERT_NEXT(a_advance_gives_result, clock, reset, advance, rsp_valid_ff)
   `ASSERT_IMPLIES(a_unknown_is_changed, clock, reset, rsp_valid && !rsp_data.known_id, rsp_data.changed)
   `ASSERT_IMPLIES(a_empty_frame_unchanged, clock, reset, in_valid_ff && status.known_id && len_sat == '0, !status.changed)

endmodule

`default_nettype wire
